// ===== src/typed_handle_table_next_fit_defines.svh =====
// Assertion helpers for the handle table RTL (used by thtnf_back).
`ifndef TYPED_HANDLE_TABLE_NEXT_FIT_DEFINES_SVH
`define TYPED_HANDLE_TABLE_NEXT_FIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define THTNF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thtnf: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define THTNF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thtnf: next-cycle check failed");

`endif

// ===== src/thtnf_pkg.sv =====
`default_nettype none

package thtnf_pkg;

    localparam int TABLE_SLOTS = 1024;

    localparam int IDX_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int HINT_W    = $clog2(TABLE_SLOTS + 1);
    localparam int ROW_W     = 32;
    localparam int BIT_W     = 5;
    localparam int NROWS     = (TABLE_SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_IDX_W = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int RCNT_W    = $clog2(NROWS + 1);
    localparam int POS_W     = ROW_IDX_W + BIT_W;

    localparam int KIND_W    = 2;
    localparam int HANDLE_W  = 32;
    localparam int TYPE_W    = 3;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int RHANDLE_W = 31;
    localparam int HSHIFT    = 6;
    localparam int HFIELD_W  = 24;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_REMOVE,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [TYPE_W-1:0]  etype;
        logic [DATA_W-1:0]  payload;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REJECT,
        S_CHK_RD,
        S_CHK_EV,
        S_SRCH_RD,
        S_SRCH_EV
    } t_bstate;

endpackage

`default_nettype wire

// ===== src/thtnf_ifs.sv =====
`default_nettype none

interface thtnf_req_if;
    import thtnf_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [TYPE_W-1:0]   entry_type;
    logic [DATA_W-1:0]   payload;

    modport source (output valid, kind, handle, entry_type, payload, input ready);
    modport sink   (input valid, kind, handle, entry_type, payload, output ready);
endinterface

interface thtnf_rsp_if;
    import thtnf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [RHANDLE_W-1:0] result_handle;
    logic [DATA_W-1:0]    result_payload;

    modport source (output valid, status, result_handle, result_payload, input ready);
    modport sink   (input valid, status, result_handle, result_payload, output ready);
endinterface

`default_nettype wire

// ===== src/thtnf_front.sv =====
`default_nettype none

module thtnf_front (
    thtnf_req_if.sink         i_req,
    input  logic              i_clearing,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output thtnf_pkg::t_cmd   o_cmd
);
    import thtnf_pkg::*;

    logic [HFIELD_W-1:0] w_field;
    logic                w_fmt_ok;

    always_comb begin
        w_field  = i_req.handle[HSHIFT +: HFIELD_W];
        w_fmt_ok = !i_req.handle[HANDLE_W-1] && i_req.handle[HANDLE_W-2]
                   && (i_req.handle[HSHIFT-1:0] == '0)
                   && ({1'b0, w_field} < (HFIELD_W + 1)'(TABLE_SLOTS))
                   && (w_field != '0);

        o_cmd.idx     = w_field[IDX_W-1:0];
        o_cmd.etype   = i_req.entry_type;
        o_cmd.payload = i_req.payload;
        case (i_req.kind)
            KIND_INSERT: o_cmd.op = OP_INSERT;
            KIND_LOOKUP: o_cmd.op = w_fmt_ok ? OP_LOOKUP : OP_REJECT;
            KIND_REMOVE: o_cmd.op = w_fmt_ok ? OP_REMOVE : OP_REJECT;
            default:     o_cmd.op = OP_REJECT;
        endcase
    end

    assign o_cmd_valid = i_req.valid && !i_clearing;
    assign i_req.ready = i_cmd_ready && !i_clearing;

endmodule

`default_nettype wire

// ===== src/thtnf_queue.sv =====
`default_nettype none

module thtnf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  thtnf_pkg::t_cmd   i_push_cmd,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output thtnf_pkg::t_cmd   o_pop_cmd
);
    import thtnf_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/thtnf_back.sv =====
`default_nettype none
`include "typed_handle_table_next_fit_defines.svh"

module thtnf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  thtnf_pkg::t_cmd   i_cmd,
    output logic              o_clearing,
    thtnf_rsp_if.source       o_rsp
);
    import thtnf_pkg::*;

    logic [ROW_W-1:0]         m_bitmap [NROWS];
    logic [TYPE_W+DATA_W-1:0] m_data   [TABLE_SLOTS];
    logic [ROW_W-1:0]         r_bm_q;
    logic [TYPE_W+DATA_W-1:0] r_data_q;

    t_bstate               r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [RCNT_W-1:0]     r_row, n_row;
    logic                  r_phase, n_phase;
    logic [HINT_W-1:0]     r_hint, n_hint;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [RHANDLE_W-1:0]  r_out_handle, n_out_handle;
    logic [DATA_W-1:0]     r_out_payload, n_out_payload;

    logic                  w_bm_re, w_bm_we, w_dt_re, w_dt_we;
    logic [ROW_IDX_W-1:0]  w_bm_raddr, w_bm_waddr;
    logic [ROW_W-1:0]      w_bm_wdata;
    logic [ROW_W-1:0]      w_init;
    logic [ROW_W-1:0]      w_avail;
    logic                  w_found;
    logic [BIT_W-1:0]      w_fbit;
    logic [POS_W-1:0]      w_fpos;
    logic [IDX_W-1:0]      w_fidx;
    logic [31:0]           w_hint32;
    logic [POS_W-1:0]      w_cpos;
    logic [ROW_IDX_W-1:0]  w_crow;
    logic [BIT_W-1:0]      w_cbit;
    logic                  w_chk_ok;
    logic                  w_out_free;

    always_comb begin
        w_hint32 = 32'(r_hint);
        w_cpos   = POS_W'(r_cmd.idx);
        w_crow   = w_cpos[POS_W-1:BIT_W];
        w_cbit   = w_cpos[BIT_W-1:0];
        w_chk_ok = r_bm_q[w_cbit] && (r_data_q[DATA_W +: TYPE_W] == r_cmd.etype);

        for (int j = 0; j < ROW_W; j++) begin
            w_init[j] = ((int'(r_row) * ROW_W + j) == 0)
                        || ((int'(r_row) * ROW_W + j) >= TABLE_SLOTS);
        end

        w_avail = ~r_bm_q;
        if (!r_phase && (r_row == RCNT_W'(w_hint32 >> BIT_W))) begin
            w_avail = w_avail & ({ROW_W{1'b1}} << w_hint32[BIT_W-1:0]);
        end
        w_found = |w_avail;
        w_fbit  = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (w_avail[j]) begin
                w_fbit = BIT_W'(j);
            end
        end
        w_fpos = {r_row[ROW_IDX_W-1:0], w_fbit};
        w_fidx = w_fpos[IDX_W-1:0];
    end

    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_row         = r_row;
        n_phase       = r_phase;
        n_hint        = r_hint;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_handle  = r_out_handle;
        n_out_payload = r_out_payload;
        w_bm_re       = 1'b0;
        w_bm_raddr    = w_crow;
        w_bm_we       = 1'b0;
        w_bm_waddr    = r_row[ROW_IDX_W-1:0];
        w_bm_wdata    = w_init;
        w_dt_re       = 1'b0;
        w_dt_we       = 1'b0;
        o_cmd_ready   = 1'b0;
        o_clearing    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_clearing = 1'b1;
                w_bm_we    = 1'b1;
                n_row      = r_row + RCNT_W'(1);
                if (r_row == RCNT_W'(NROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        OP_INSERT: begin
                            n_row   = RCNT_W'(w_hint32 >> BIT_W);
                            n_phase = 1'b0;
                            n_state = S_SRCH_RD;
                        end
                        OP_LOOKUP, OP_REMOVE: n_state = S_CHK_RD;
                        default:              n_state = S_REJECT;
                    endcase
                end
            end
            S_REJECT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = ST_INVALID;
                    n_out_handle  = '0;
                    n_out_payload = '0;
                    n_state       = S_IDLE;
                end
            end
            S_CHK_RD: begin
                w_bm_re = 1'b1;
                w_dt_re = 1'b1;
                n_state = S_CHK_EV;
            end
            S_CHK_EV: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = w_chk_ok ? ST_OK : ST_INVALID;
                    n_out_handle  = '0;
                    n_out_payload = w_chk_ok ? r_data_q[DATA_W-1:0] : '0;
                    n_state       = S_IDLE;
                    if (w_chk_ok && (r_cmd.op == OP_REMOVE)) begin
                        w_bm_we    = 1'b1;
                        w_bm_waddr = w_crow;
                        w_bm_wdata = r_bm_q & ~(ROW_W'(1) << w_cbit);
                        if (HINT_W'(r_cmd.idx) < r_hint) begin
                            n_hint = HINT_W'(r_cmd.idx);
                        end
                    end
                end
            end
            S_SRCH_RD: begin
                w_bm_raddr = r_row[ROW_IDX_W-1:0];
                if (r_row == RCNT_W'(NROWS)) begin
                    if (!r_phase && (r_hint != HINT_W'(1))) begin
                        n_phase = 1'b1;
                        n_row   = '0;
                    end else if (w_out_free) begin
                        n_out_valid   = 1'b1;
                        n_out_status  = ST_FULL;
                        n_out_handle  = '0;
                        n_out_payload = '0;
                        n_state       = S_IDLE;
                    end
                end else begin
                    w_bm_re = 1'b1;
                    n_state = S_SRCH_EV;
                end
            end
            S_SRCH_EV: begin
                if (!w_found) begin
                    n_row   = r_row + RCNT_W'(1);
                    n_state = S_SRCH_RD;
                end else if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = ST_OK;
                    n_out_handle  = {1'b1, HFIELD_W'(w_fidx), HSHIFT'(0)};
                    n_out_payload = '0;
                    w_bm_we       = 1'b1;
                    w_bm_wdata    = r_bm_q | (ROW_W'(1) << w_fbit);
                    w_dt_we       = 1'b1;
                    n_hint        = HINT_W'(w_fidx) + HINT_W'(1);
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_phase     <= 1'b0;
            r_hint      <= HINT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_phase     <= n_phase;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_out_status  <= n_out_status;
        r_out_handle  <= n_out_handle;
        r_out_payload <= n_out_payload;
    end

    always_ff @(posedge i_clk) begin
        if (w_bm_we) begin
            m_bitmap[w_bm_waddr] <= w_bm_wdata;
        end
        if (w_bm_re) begin
            r_bm_q <= m_bitmap[w_bm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dt_we) begin
            m_data[w_fidx] <= {r_cmd.etype, r_cmd.payload};
        end
        if (w_dt_re) begin
            r_data_q <= m_data[r_cmd.idx];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.result_handle  = r_out_handle;
    assign o_rsp.result_payload = r_out_payload;

    `THTNF_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR, !r_out_valid && !o_cmd_ready)
    `THTNF_ASSERT_IMP(a_hint_range, i_clk, i_rst_n, 1'b1, (r_hint != '0) && (32'(r_hint) <= TABLE_SLOTS))
    `THTNF_ASSERT_NXT(a_insert_done, i_clk, i_rst_n, (r_state == S_SRCH_EV) && w_found && w_out_free, r_out_valid && (r_out_status == ST_OK) && r_out_handle[RHANDLE_W-1])
    `THTNF_ASSERT_IMP(a_full_zero, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_FULL), (r_out_handle == '0) && (r_out_payload == '0))

endmodule

`default_nettype wire

// ===== src/typed_handle_table_next_fit.sv =====
// Typed handle table with next-fit slot allocation.
// i_req carries one request per item: kind (insert, lookup, remove), handle,
// entry_type and payload. o_rsp returns exactly one item per request: status,
// result_handle (insert only) and result_payload (lookup and remove only).
// A request enters a two-deep command queue after decode; a sequencer owns the
// occupancy bitmap (32 slots per row) and the type/payload memory.
// Lookup and remove pass through the sequencer states S_CHK_RD, which reads the
// bitmap row and the memory, and S_CHK_EV, which registers the result for o_rsp.
// Insert scans one bitmap row at a time (read, then evaluate) from the next-fit
// pointer and wraps at most once to row 0, answering full if no slot is free.
// The memory read port and the one-item-at-a-time sequencer set the rate.
// After reset the sequencer sweeps the bitmap, one row per cycle, through all
// TABLE_SLOTS / 32 rows (32 at 1024 slots); i_req.ready stays low meanwhile.
// If o_rsp stalls, one result waits in the output register while the next
// command proceeds up to its result and the queue accepts up to two requests.
`default_nettype none

module typed_handle_table_next_fit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thtnf_req_if.sink   i_req,
    thtnf_rsp_if.source o_rsp
);
    import thtnf_pkg::*;

    logic w_clearing;
    logic w_fq_valid, w_fq_ready;
    logic w_qb_valid, w_qb_ready;
    t_cmd w_fq_cmd, w_qb_cmd;

    thtnf_front u_front (
        .i_req       (i_req),
        .i_clearing  (w_clearing),
        .o_cmd_valid (w_fq_valid),
        .i_cmd_ready (w_fq_ready),
        .o_cmd       (w_fq_cmd)
    );

    thtnf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_cmd   (w_fq_cmd),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_cmd    (w_qb_cmd)
    );

    thtnf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qb_valid),
        .o_cmd_ready (w_qb_ready),
        .i_cmd       (w_qb_cmd),
        .o_clearing  (w_clearing),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
